FILE: rtl/core/ets_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and status bundle of the template error scorer.
package ets_pkg;

    localparam int SEG_LEN    = 512;
    localparam int IDX_W      = 9;
    localparam int SMP_W      = 16;
    localparam int SUM_W      = 48;
    localparam int TERM_W     = 32;
    localparam int DIST_W     = 43;
    localparam int NORM_W     = 25;
    localparam int DIV_STEPS  = 13;
    localparam int CNT_W      = 4;
    localparam int COS_ONE    = 4096;
    localparam int PI_Q12     = 12868;
    localparam int IN_TDATA_W = 64;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_VSQ,
        OP_ACC,
        OP_DA,
        OP_DB,
        OP_DC,
        OP_NUM,
        OP_NORM,
        OP_MULN,
        OP_MULD,
        OP_DCHK,
        OP_DIV,
        OP_ANG,
        OP_ERR,
        OP_ESQ,
        OP_UPD
    } t_op;

    typedef struct packed {
        logic pts_full;
        logic norm_more;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

FILE: rtl/core/ets_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps the datapath through one template point.
module ets_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ets_pkg::t_stat i_stat,
    output ets_pkg::t_op  o_op
);
    import ets_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VSQ, S_VACC, S_DA, S_DB, S_DC, S_NUM, S_NORM,
        S_MULD, S_DCHK, S_DIV, S_ANG, S_ERR, S_ESQ, S_EACC, S_UPD
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_VSQ;
                end
            end
            S_VSQ: begin
                o_op    = OP_VSQ;
                n_state = S_VACC;
            end
            S_VACC: begin
                o_op    = OP_ACC;
                n_state = i_stat.pts_full ? S_DA : S_UPD;
            end
            S_DA: begin
                o_op    = OP_DA;
                n_state = S_DB;
            end
            S_DB: begin
                o_op    = OP_DB;
                n_state = S_DC;
            end
            S_DC: begin
                o_op    = OP_DC;
                n_state = S_NUM;
            end
            S_NUM: begin
                o_op    = OP_NUM;
                n_state = S_NORM;
            end
            S_NORM: begin
                // shift one bit a cycle until all three fit the multiplier
                if (i_stat.norm_more) begin
                    o_op = OP_NORM;
                end else begin
                    o_op    = OP_MULN;
                    n_state = S_MULD;
                end
            end
            S_MULD: begin
                o_op    = OP_MULD;
                n_state = S_DCHK;
            end
            S_DCHK: begin
                o_op    = OP_DCHK;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op  = OP_DIV;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ANG;
                end
            end
            S_ANG: begin
                o_op    = OP_ANG;
                n_state = S_ERR;
            end
            S_ERR: begin
                o_op    = OP_ERR;
                n_state = S_ESQ;
            end
            S_ESQ: begin
                o_op    = OP_ESQ;
                n_state = S_EACC;
            end
            S_EACC: begin
                o_op    = OP_ACC;
                n_state = S_UPD;
            end
            S_UPD: begin
                // on a last point, hold while the previous result still waits
                if (!(i_stat.last && i_stat.out_busy)) begin
                    o_op    = OP_UPD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/core/ets_datapath.sv
`timescale 1ns / 1ps
// Arithmetic, point window, accumulator and result register of the scorer.
module ets_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ets_pkg::t_op              i_op,
    input  logic [ets_pkg::IDX_W-1:0] i_sample_index,
    input  logic signed [ets_pkg::SMP_W-1:0] i_template_value,
    input  logic signed [ets_pkg::SMP_W-1:0] i_template_angle,
    input  logic signed [ets_pkg::SMP_W-1:0] i_source_value,
    input  logic                      i_last_point,
    input  logic                      i_m_tready,
    output ets_pkg::t_stat            o_stat,
    output logic                      o_out_valid,
    output logic [ets_pkg::SUM_W-1:0] o_error_sum,
    output logic                      o_saturated
);
    import ets_pkg::*;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // current item
    logic [IDX_W-1:0]        r_idx;
    logic signed [SMP_W-1:0] r_tv, r_ta, r_sv;
    logic                    r_last;
    // window of previous points
    logic [IDX_W-1:0]        r_old_idx, r_new_idx;
    logic signed [SMP_W-1:0] r_old_src, r_new_src, r_pta;
    logic [1:0]              r_pts;
    // accumulator
    logic [SUM_W-1:0]        r_sum;
    logic                    r_clip;
    logic [TERM_W-1:0]       r_term;
    // angle term
    logic [DIST_W-1:0]       r_aa, r_bb, r_cc;
    logic [DIST_W:0]         r_n, r_b, r_c;
    logic [2*NORM_W-1:0]     r_nsq;
    logic [2*NORM_W+1:0]     r_den;
    logic [2*NORM_W+11:0]    r_rem;
    logic [2*NORM_W+13:0]    r_dsh;
    logic                    r_ovf;
    logic [DIV_STEPS-1:0]    r_q;
    logic [26:0]             r_t;
    logic signed [SMP_W:0]   r_e;
    // result register
    logic                    r_out_valid;
    logic [SUM_W-1:0]        r_out_sum;
    logic                    r_out_sat;

    logic [IDX_W-1:0]        idx_clamped;
    logic [IDX_W-1:0]        xa, xb;
    logic signed [SMP_W-1:0] ya, yb;
    logic signed [IDX_W:0]   dx;
    logic [IDX_W-1:0]        dx_mag;
    logic signed [SMP_W:0]   dy;
    logic [SMP_W-1:0]        dy_mag;
    logic [DIST_W-1:0]       dist_val;
    logic signed [SMP_W:0]   sq_in;
    logic [SMP_W-1:0]        sq_mag;
    logic signed [DIST_W+1:0] num;
    logic [DIST_W:0]         num_mag;
    logic [SUM_W:0]          acc_sum;
    logic                    div_ge;
    logic [DIV_STEPS-1:0]    cos2;
    logic [13:0]             rnd;

    assign idx_clamped = ({1'b0, i_sample_index} >= (IDX_W+1)'(SEG_LEN))
                       ? IDX_W'(SEG_LEN - 1) : i_sample_index;

    // shared squared-distance unit
    always_comb begin
        case (i_op)
            OP_DA: begin
                xa = r_old_idx; ya = r_old_src; xb = r_idx; yb = r_sv;
            end
            OP_DB: begin
                xa = r_new_idx; ya = r_new_src; xb = r_idx; yb = r_sv;
            end
            default: begin
                xa = r_old_idx; ya = r_old_src; xb = r_new_idx; yb = r_new_src;
            end
        endcase
    end
    assign dx       = $signed({1'b0, xb}) - $signed({1'b0, xa});
    assign dx_mag   = dx[IDX_W] ? IDX_W'(-dx) : dx[IDX_W-1:0];
    assign dy       = {yb[SMP_W-1], yb} - {ya[SMP_W-1], ya};
    assign dy_mag   = dy[SMP_W] ? SMP_W'(-dy) : dy[SMP_W-1:0];
    assign dist_val = {1'b0, (2*IDX_W)'(dx_mag * dx_mag), 24'b0}
                    + DIST_W'((2*SMP_W)'(dy_mag * dy_mag));

    // shared squaring unit for value and angle errors
    assign sq_in  = (i_op == OP_ESQ) ? r_e
                  : ({r_tv[SMP_W-1], r_tv} - {r_sv[SMP_W-1], r_sv});
    assign sq_mag = sq_in[SMP_W] ? SMP_W'(-sq_in) : sq_in[SMP_W-1:0];

    assign num     = $signed({2'b0, r_bb}) + $signed({2'b0, r_cc}) - $signed({2'b0, r_aa});
    assign num_mag = num[DIST_W+1] ? (DIST_W+1)'(-num) : num[DIST_W:0];

    assign acc_sum = {1'b0, r_sum} + (SUM_W+1)'(r_term);

    assign div_ge = {2'b0, r_rem} >= r_dsh;

    always_comb begin
        if (r_den == '0) begin
            cos2 = '0;
        end else if (r_ovf || (r_q > DIV_STEPS'(COS_ONE))) begin
            cos2 = DIV_STEPS'(COS_ONE);
        end else begin
            cos2 = r_q;
        end
    end
    assign rnd = 14'((r_t + 27'd2048) >> 12);

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_idx  <= idx_clamped;
                r_tv   <= i_template_value;
                r_ta   <= i_template_angle;
                r_sv   <= i_source_value;
                r_last <= i_last_point;
            end
            OP_VSQ, OP_ESQ: r_term <= TERM_W'(sq_mag * sq_mag);
            OP_DA: r_aa <= dist_val;
            OP_DB: r_bb <= dist_val;
            OP_DC: r_cc <= dist_val;
            OP_NUM: begin
                r_n <= num_mag;
                r_b <= {1'b0, r_bb};
                r_c <= {1'b0, r_cc};
            end
            OP_NORM: begin
                r_n <= r_n >> 1;
                r_b <= r_b >> 1;
                r_c <= r_c >> 1;
            end
            OP_MULN: r_nsq <= r_n[NORM_W-1:0] * r_n[NORM_W-1:0];
            OP_MULD: r_den <= {(2*NORM_W)'(r_b[NORM_W-1:0] * r_c[NORM_W-1:0]), 2'b0};
            OP_DCHK: begin
                r_rem <= {r_nsq, 12'b0};
                r_dsh <= {r_den, 12'b0};
                r_ovf <= {3'b0, r_nsq, 12'b0} >= {r_den, 13'b0};
                r_q   <= '0;
            end
            OP_DIV: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_dsh[2*NORM_W+11:0];
                end
                r_q   <= {r_q[DIV_STEPS-2:0], div_ge};
                r_dsh <= r_dsh >> 1;
            end
            OP_ANG: r_t <= 27'(14'(PI_Q12) * cos2);
            OP_ERR: r_e <= {r_pta[SMP_W-1], r_pta} + $signed({3'b0, rnd});
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_idx   <= '0;
            r_new_idx   <= '0;
            r_old_src   <= '0;
            r_new_src   <= '0;
            r_pta       <= '0;
            r_pts       <= '0;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((i_op == OP_UPD) && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_op == OP_ACC) begin
                if (acc_sum[SUM_W]) begin
                    r_sum  <= SUM_MAX;
                    r_clip <= 1'b1;
                end else begin
                    r_sum <= acc_sum[SUM_W-1:0];
                end
            end
            if (i_op == OP_UPD) begin
                r_old_idx <= r_new_idx;
                r_old_src <= r_new_src;
                r_new_idx <= r_idx;
                r_new_src <= r_sv;
                r_pta     <= r_ta;
                if (r_last) begin
                    // emit and start the next template
                    r_out_sum   <= r_sum;
                    r_out_sat   <= r_clip;
                    r_sum       <= '0;
                    r_clip      <= 1'b0;
                    r_pts       <= '0;
                end else if (r_pts != 2'd2) begin
                    r_pts <= r_pts + 1'b1;
                end
            end
        end
    end

    assign o_stat.pts_full  = (r_pts == 2'd2);
    assign o_stat.norm_more = |(r_n[DIST_W:NORM_W] | r_b[DIST_W:NORM_W] | r_c[DIST_W:NORM_W]);
    assign o_stat.last      = r_last;
    assign o_stat.out_busy  = r_out_valid && !i_m_tready;

    assign o_out_valid = r_out_valid;
    assign o_error_sum = r_out_sum;
    assign o_saturated = r_out_sat;

endmodule

FILE: rtl/core/ecg_template_error_scorer_top.sv
`timescale 1ns / 1ps
// Top level of the ECG template error scorer.
// Takes one template point per item and adds its squared value error and, for
// interior points, the squared angle error to a per-template sum that is sent
// as one item on the last point (tuser[0] flags a sum clipped at 2^48-1). An
// item that closes no interior point is loaded, squared, accumulated and stored;
// otherwise the three squared distances, the one-bit-per-cycle normalizing
// shift (0 to 19 bits), multiplies, 13-step restoring divider, angle error and
// its square run too. A finished sum waits in the output register while the next
// item runs; a last point holds in its final step until the previous sum is taken.
module ecg_template_error_scorer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [8:0] sample_index, [24:9] template_value, [40:25] template_angle,
    // [56:41] source_value, [63:57] zero
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tlast,     // last_point
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,     // [47:0] error_sum
    output logic [0:0]  o_m_tuser      // [0] saturated
);
    import ets_pkg::*;

    t_op   op;
    t_stat stat;

    ets_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    ets_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_sample_index   (i_s_tdata[8:0]),
        .i_template_value ($signed(i_s_tdata[24:9])),
        .i_template_angle ($signed(i_s_tdata[40:25])),
        .i_source_value   ($signed(i_s_tdata[56:41])),
        .i_last_point     (i_s_tlast),
        .i_m_tready       (i_m_tready),
        .o_stat           (stat),
        .o_out_valid      (o_m_tvalid),
        .o_error_sum      (o_m_tdata),
        .o_saturated      (o_m_tuser[0])
    );

endmodule

FILE: rtl/core/ets_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the scorer and its binding to the top level.
module ets_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic [0:0]  o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item accepted while previous one in work");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 48'hFFFF_FFFF_FFFF))
        else $error("saturated sum not at maximum");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind ecg_template_error_scorer_top ets_checker u_ets_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
